// ===== hdl/osre_pkg.sv =====
// Shared types, constants and helpers for the one-wire Search ROM engine.
// Used by osre_store and onewire_search_rom_engine; depends on nothing else.
`timescale 1ns / 1ps

package osre_pkg;

  // Address and field sizes.
  localparam int unsigned AddrW  = 64;
  localparam int unsigned CrcW   = 8;
  localparam int unsigned PosW   = 7;
  localparam int unsigned PassW  = 6;
  localparam int unsigned LimW   = 4;
  localparam int unsigned StatW  = 4;

  // Default store depth and register reset values.
  localparam int unsigned DefaultMaxDevices = 8;
  localparam logic [LimW-1:0]  DeviceLimitReset = 4'd8;
  localparam logic [PassW-1:0] PassLimitReset   = 6'd24;

  // Reflected CRC-8 polynomial and the accepted family codes.
  localparam logic [CrcW-1:0] CrcPoly   = 8'h8C;
  localparam logic [7:0]      FamilyA   = 8'h28;
  localparam logic [7:0]      FamilyB   = 8'h10;
  localparam logic [7:0]      FamilyC   = 8'h22;

  // Number of address bits covered by the CRC.
  localparam int unsigned CrcBits = 56;

  // Width of the stored-device counter: room for the depth, never below the
  // width of the device limit register.
  function automatic int unsigned cnt_width(input int unsigned depth);
    int unsigned w;
    w = $clog2(depth + 1);
    return (w < LimW) ? LimW : w;
  endfunction

  // One serial step of the reflected CRC-8.
  function automatic logic [CrcW-1:0] crc8_step(input logic [CrcW-1:0] crc,
                                                input logic            b);
    logic [CrcW-1:0] nxt;
    nxt = {1'b0, crc[CrcW-1:1]};
    if (crc[0] ^ b) begin
      nxt = nxt ^ CrcPoly;
    end
    return nxt;
  endfunction

  // Commands from the sequencer to the address store.
  typedef struct packed {
    logic start;  // begin a duplicate walk over the stored entries
    logic wr;     // write the address at the current count
  } osre_store_ctl_t;

  // Status from the address store back to the sequencer.
  typedef struct packed {
    logic done;   // walk finished this cycle
    logic dup;    // a stored entry matched the address
  } osre_store_sts_t;

endpackage

// ===== hdl/osre_store.sv =====
// Address store of the Search ROM engine: the found-address memory and the
// duplicate walk that compares one stored entry per cycle. Uses osre_pkg.
`timescale 1ns / 1ps

module osre_store #(
  parameter int unsigned MAX_DEVICES = osre_pkg::DefaultMaxDevices
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  osre_pkg::osre_store_ctl_t                       ctl_i,
  input  logic [osre_pkg::cnt_width(MAX_DEVICES)-1:0]     count_i,
  input  logic [osre_pkg::AddrW-1:0]                      addr_i,
  output osre_pkg::osre_store_sts_t                       sts_o
);
  import osre_pkg::*;

  localparam int unsigned CntW = cnt_width(MAX_DEVICES);
  localparam int unsigned IdxW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

  logic [AddrW-1:0] mem_q [MAX_DEVICES];
  logic [AddrW-1:0] rd_q;
  logic             active_q;
  logic             pend_q;
  logic             dup_q;
  logic [CntW-1:0]  idx_q;
  logic             launch;

  // A read is issued while entries below the count remain.
  assign launch = active_q && (idx_q < count_i);

  // Memory write and registered read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[count_i[IdxW-1:0]] <= addr_i;
    end
    if (launch) begin
      rd_q <= mem_q[idx_q[IdxW-1:0]];
    end
  end

  // Walk control: one read issued and one compare done per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pend_q   <= 1'b0;
      dup_q    <= 1'b0;
      idx_q    <= '0;
    end else if (ctl_i.start) begin
      active_q <= 1'b1;
      pend_q   <= 1'b0;
      dup_q    <= 1'b0;
      idx_q    <= '0;
    end else if (active_q) begin
      if (pend_q && (rd_q == addr_i)) begin
        dup_q <= 1'b1;
      end
      pend_q <= launch;
      if (launch) begin
        idx_q <= idx_q + 1'b1;
      end
      if (!launch && !pend_q) begin
        active_q <= 1'b0;
      end
    end
  end

  // The walk is over once nothing is left to read or compare.
  assign sts_o.done = active_q && !launch && !pend_q;
  assign sts_o.dup  = dup_q;

endmodule

// ===== hdl/onewire_search_rom_engine.sv =====
// Top level of the one-wire Search ROM decision engine: handshakes, search
// state, the step sequencer and the result register. Uses osre_pkg, osre_store.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake              Payload
//  --------  ---------  ---------------------  -----------------------------------------
//  in        input      in_valid_i/in_stall_o  kind, presence, id_bit, complement_bit
//  out       output     out_valid_o/out_stall_i direction, status, address,
//                                              device_count, scan_finished
//  cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A request passes through capture, execute and hand-off to the result register.
// A bit pair that completes the address adds a classing step and, for a known
// family with a good CRC, a walk through the address memory that covers every
// stored device, one read and one compare per cycle.
// Reset is asynchronous and active low; the address memory is not cleared.
// A stalled result waits in the result register while the next request starts.

module onewire_search_rom_engine #(
  parameter int unsigned MAX_DEVICES = osre_pkg::DefaultMaxDevices
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic                          presence_i,
  input  logic                          id_bit_i,
  input  logic                          complement_bit_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          direction_o,
  output logic [osre_pkg::StatW-1:0]    status_o,
  output logic [osre_pkg::AddrW-1:0]    address_o,
  output logic [osre_pkg::LimW-1:0]     device_count_o,
  output logic                          scan_finished_o,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [osre_pkg::PassW-1:0]    cfg_data_i
);
  import osre_pkg::*;

  localparam int unsigned CntW = cnt_width(MAX_DEVICES);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_DEVICES);

  typedef enum logic [1:0] {
    KIND_SCAN = 2'd0,
    KIND_PASS = 2'd1,
    KIND_BIT  = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [StatW-1:0] {
    ST_BIT_TAKEN   = 4'd0,
    ST_NO_PRESENCE = 4'd1,
    ST_NO_RESPONSE = 4'd2,
    ST_CRC_RETRY   = 4'd3,
    ST_FAMILY_SKIP = 4'd4,
    ST_DUPLICATE   = 4'd5,
    ST_FOUND       = 4'd6,
    ST_PASS_START  = 4'd7,
    ST_SCAN_START  = 4'd8,
    ST_IGNORED     = 4'd9
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_BETWEEN = 2'd1,
    PH_PASS    = 2'd2,
    PH_DONE    = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CLOSE,
    S_WALK,
    S_SEND
  } state_e;

  localparam logic CfgDeviceLimit = 1'b0;
  localparam logic CfgPassLimit   = 1'b1;

  // Configuration registers.
  logic [LimW-1:0]  dev_lim_q;
  logic [PassW-1:0] pass_lim_q;

  // Sequencer and captured request.
  state_e           state_q;
  kind_e            kind_q;
  logic             pres_q;
  logic             idb_q;
  logic             cmp_q;

  // Search state.
  phase_e           phase_q;
  logic [PosW-1:0]  last_conf_q;
  logic [PosW-1:0]  pass_conf_q;
  logic [AddrW-1:0] prev_addr_q;
  logic [AddrW-1:0] cur_addr_q;
  logic [PosW-1:0]  bit_pos_q;
  logic [CrcW-1:0]  crc_q;
  logic [CntW-1:0]  cnt_q;
  logic [PassW-1:0] passes_q;

  // Step result held until the result register is free.
  logic             dir_q;
  status_e          st_q;

  // Result register.
  logic             out_valid_q;
  logic             out_dir_q;
  status_e          out_st_q;
  logic [AddrW-1:0] out_addr_q;
  logic [LimW-1:0]  out_cnt_q;
  logic             out_fin_q;

  // Decision logic and store handshake.
  logic [5:0]       idx;
  logic [PosW-1:0]  pos;
  logic             pair_dir;
  logic             pair_conf;
  logic             exec_dir;
  status_e          exec_st;
  logic             exec_close;
  logic             send_fire;
  logic [CntW-1:0]  eff_lim;
  logic [7:0]       family;
  logic             family_ok;
  logic             crc_ok;
  logic             store_room;
  logic [CntW-1:0]  cnt_after;
  osre_store_ctl_t  store_ctl;
  osre_store_sts_t  store_sts;

  // Device limit clamped to the store depth.
  assign eff_lim = (CntW'(dev_lim_q) > MaxCnt) ? MaxCnt : CntW'(dev_lim_q);

  function automatic logic limits_hit(input logic [CntW-1:0]  cnt,
                                      input logic [PassW-1:0] passes);
    return (cnt >= eff_lim) || (passes >= pass_lim_q);
  endfunction

  // Direction choice by the last-discrepancy rule.
  always_comb begin
    idx       = bit_pos_q[5:0];
    pos       = {1'b0, idx} + 7'd1;
    pair_conf = 1'b0;
    if (idb_q != cmp_q) begin
      pair_dir = idb_q;
    end else begin
      if (pos == last_conf_q) begin
        pair_dir = 1'b1;
      end else if (pos > last_conf_q) begin
        pair_dir = 1'b0;
      end else begin
        pair_dir = prev_addr_q[idx];
      end
      pair_conf = !pair_dir;
    end
  end

  // Direction, status and next step of the request being executed.
  always_comb begin
    exec_dir   = 1'b0;
    exec_st    = ST_IGNORED;
    exec_close = 1'b0;
    unique case (kind_q)
      KIND_SCAN: begin
        exec_st = ST_SCAN_START;
      end
      KIND_PASS: begin
        if ((phase_q == PH_BETWEEN) && !limits_hit(cnt_q, passes_q)) begin
          exec_st = pres_q ? ST_PASS_START : ST_NO_PRESENCE;
        end
      end
      KIND_BIT: begin
        if (phase_q == PH_PASS) begin
          if (idb_q && cmp_q) begin
            exec_st = ST_NO_RESPONSE;
          end else begin
            exec_dir   = pair_dir;
            exec_st    = ST_BIT_TAKEN;
            exec_close = (pos == 7'(AddrW));
          end
        end
      end
      default: ;
    endcase
  end

  // The result register takes the step result once it is free or being read.
  assign send_fire = (state_q == S_SEND) && (!out_valid_q || !out_stall_i);

  // End-of-pass checks.
  assign family     = cur_addr_q[7:0];
  assign family_ok  = (family == FamilyA) || (family == FamilyB) || (family == FamilyC);
  assign crc_ok     = (crc_q == cur_addr_q[AddrW-1:AddrW-8]);
  assign store_room = (cnt_q < MaxCnt);
  assign cnt_after  = (!store_sts.dup && store_room) ? cnt_q + 1'b1 : cnt_q;

  assign store_ctl.start = (state_q == S_CLOSE) && crc_ok && family_ok;
  assign store_ctl.wr    = (state_q == S_WALK) && store_sts.done && !store_sts.dup
                           && store_room;

  osre_store #(
    .MAX_DEVICES (MAX_DEVICES)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (store_ctl),
    .count_i (cnt_q),
    .addr_i  (cur_addr_q),
    .sts_o   (store_sts)
  );

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_lim_q  <= DeviceLimitReset;
      pass_lim_q <= PassLimitReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDeviceLimit: dev_lim_q  <= cfg_data_i[LimW-1:0];
        CfgPassLimit:   pass_lim_q <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // Sequencer, search state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= KIND_NONE;
      pres_q      <= 1'b0;
      idb_q       <= 1'b0;
      cmp_q       <= 1'b0;
      phase_q     <= PH_IDLE;
      last_conf_q <= '0;
      pass_conf_q <= '0;
      prev_addr_q <= '0;
      cur_addr_q  <= '0;
      bit_pos_q   <= '0;
      crc_q       <= '0;
      cnt_q       <= '0;
      passes_q    <= '0;
      dir_q       <= 1'b0;
      st_q        <= ST_IGNORED;
      out_valid_q <= 1'b0;
      out_dir_q   <= 1'b0;
      out_st_q    <= ST_IGNORED;
      out_addr_q  <= '0;
      out_cnt_q   <= '0;
      out_fin_q   <= 1'b0;
    end else begin
      // A new result fills the register; a taken result frees it.
      if (send_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q  <= kind_e'(kind_i);
            pres_q  <= presence_i;
            idb_q   <= id_bit_i;
            cmp_q   <= complement_bit_i;
            state_q <= S_EXEC;
          end
        end

        S_EXEC: begin
          dir_q   <= exec_dir;
          st_q    <= exec_st;
          state_q <= exec_close ? S_CLOSE : S_SEND;
          unique case (kind_q)
            KIND_SCAN: begin
              last_conf_q <= '0;
              pass_conf_q <= '0;
              prev_addr_q <= '0;
              cur_addr_q  <= '0;
              bit_pos_q   <= '0;
              crc_q       <= '0;
              cnt_q       <= '0;
              passes_q    <= '0;
              phase_q     <= limits_hit('0, '0) ? PH_DONE : PH_BETWEEN;
            end
            KIND_PASS: begin
              if (phase_q == PH_BETWEEN) begin
                if (limits_hit(cnt_q, passes_q)) begin
                  phase_q <= PH_DONE;
                end else begin
                  passes_q    <= passes_q + 1'b1;
                  cur_addr_q  <= '0;
                  bit_pos_q   <= '0;
                  crc_q       <= '0;
                  pass_conf_q <= '0;
                  phase_q     <= pres_q ? PH_PASS : PH_DONE;
                end
              end
            end
            KIND_BIT: begin
              if (phase_q == PH_PASS) begin
                if (idb_q && cmp_q) begin
                  phase_q <= PH_DONE;
                end else begin
                  if (pair_conf) begin
                    pass_conf_q <= pos;
                  end
                  cur_addr_q[idx] <= cur_addr_q[idx] | pair_dir;
                  if (32'(idx) < CrcBits) begin
                    crc_q <= crc8_step(crc_q, pair_dir);
                  end
                  bit_pos_q <= pos;
                end
              end
            end
            default: ;
          endcase
        end

        // Class the completed pass.
        S_CLOSE: begin
          if (!crc_ok) begin
            st_q    <= ST_CRC_RETRY;
            phase_q <= limits_hit(cnt_q, passes_q) ? PH_DONE : PH_BETWEEN;
            state_q <= S_SEND;
          end else if (!family_ok) begin
            st_q        <= ST_FAMILY_SKIP;
            prev_addr_q <= cur_addr_q;
            last_conf_q <= pass_conf_q;
            phase_q     <= ((pass_conf_q == '0) || limits_hit(cnt_q, passes_q))
                           ? PH_DONE : PH_BETWEEN;
            state_q     <= S_SEND;
          end else begin
            state_q <= S_WALK;
          end
        end

        // Wait for the duplicate walk, then store a new device.
        S_WALK: begin
          if (store_sts.done) begin
            st_q        <= store_sts.dup ? ST_DUPLICATE : ST_FOUND;
            cnt_q       <= cnt_after;
            prev_addr_q <= cur_addr_q;
            last_conf_q <= pass_conf_q;
            phase_q     <= ((pass_conf_q == '0) || limits_hit(cnt_after, passes_q))
                           ? PH_DONE : PH_BETWEEN;
            state_q     <= S_SEND;
          end
        end

        S_SEND: begin
          if (send_fire) begin
            out_dir_q  <= dir_q;
            out_st_q   <= st_q;
            out_addr_q <= cur_addr_q;
            out_cnt_q  <= cnt_q[LimW-1:0];
            out_fin_q  <= (phase_q == PH_DONE);
            state_q    <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign direction_o     = out_dir_q;
  assign status_o        = out_st_q;
  assign address_o       = out_addr_q;
  assign device_count_o  = out_cnt_q;
  assign scan_finished_o = out_fin_q;

  // The pass position never runs past the last address bit.
  a_bit_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_pos_q <= 7'(AddrW))
    else $error("bit position beyond address width");

  // A pass in progress at rest always has bits left to take.
  a_pass_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && phase_q == PH_PASS) |-> (bit_pos_q < 7'(AddrW)))
    else $error("pass left open with a full address");

  // The store is never written beyond its depth.
  a_store_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_ctl.wr |-> (cnt_q < MaxCnt))
    else $error("store write with no room");

  // A walk only starts from the classing step and ends in the walk state.
  a_walk_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_sts.done |-> (state_q == S_WALK))
    else $error("store walk ended outside the walk state");

endmodule
